// ----- src/lrul_pkg.sv -----
// Package: sizes, write-request and result types shared by the recency list block.
package lrul_pkg;

    localparam int DEPTH    = 8;
    localparam int TAG_BITS = 16;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CFG_W    = 4;
    localparam int POS_W    = 3;

    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [IDX_W-1:0]    idx_t;

    typedef struct packed {
        logic en;
        idx_t addr;
        tag_t data;
    } lrul_wr_t;

    typedef struct packed {
        logic             is_entry_dump;
        logic             hit;
        logic [POS_W-1:0] found_position;
        logic             evicted_valid;
        tag_t             evicted_tag;
        tag_t             dump_tag;
        logic             last;
    } lrul_res_t;

endpackage

// ----- src/lrul_if.sv -----
// Interfaces: access, result and configuration channels of the recency list block.
interface lrul_access_if;
    logic                           valid;
    logic                           ready;
    logic [lrul_pkg::TAG_BITS-1:0]  tag_value;
    logic                           final_access;

    modport source (output valid, output tag_value, output final_access, input ready);
    modport sink   (input valid, input tag_value, input final_access, output ready);
endinterface

interface lrul_result_if;
    logic                           valid;
    logic                           ready;
    logic                           is_entry_dump;
    logic                           hit;
    logic [lrul_pkg::POS_W-1:0]     found_position;
    logic                           evicted_valid;
    logic [lrul_pkg::TAG_BITS-1:0]  evicted_tag;
    logic [lrul_pkg::TAG_BITS-1:0]  dump_tag;
    logic                           last;

    modport source (output valid, output is_entry_dump, output hit, output found_position,
                    output evicted_valid, output evicted_tag, output dump_tag,
                    output last, input ready);
    modport sink   (input valid, input is_entry_dump, input hit, input found_position,
                    input evicted_valid, input evicted_tag, input dump_tag,
                    input last, output ready);
endinterface

interface lrul_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lrul_pkg::CFG_W-1:0]     active_entries;

    modport source (output valid, output active_entries, input ready);
    modport sink   (input valid, input active_entries, output ready);
endinterface

// ----- src/lrul_store.sv -----
// Recency list store: synchronous RAM, one read and one write port, per-entry valid bits.
module lrul_store
(
    input  logic               clk,
    input  logic               rst_n,
    input  lrul_pkg::lrul_wr_t wr,
    input  lrul_pkg::idx_t     rd_addr,
    output lrul_pkg::tag_t     rd_data
);
    import lrul_pkg::*;

    tag_t             mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    tag_t             data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // never-written entries read as empty
    assign rd_data = rd_vld_reg ? data_reg : '0;

endmodule

// ----- src/lru_recency_list.sv -----
// Top level: LRU recency list with scan-and-rotate sequencer over a single RAM.
//
// Channels: 'access' takes one tag beat (tag_value, final_access); 'result'
// returns one report beat per access (hit, found_position, eviction), then,
// when final_access is set, one dump beat per active slot, front first, with
// 'last' on the final beat caused by the access. 'cfg' writes active_entries
// and is always ready; write it only while the block is idle.
// Timing: the access scan reads one slot per cycle through the RAM read port
// and rotates the list behind it, writing the previous slot value back one
// slot further on. Once the scan stops, the report is loaded; the block is
// ready for the next access the cycle after the report (for a final access,
// the last dump beat) is loaded. A dump adds one beat per active slot, one per
// cycle while the receiver takes them. A zero tag skips the scan.
// The result beat sits in an output register, so a new access is taken while
// the last report still waits; a stalled receiver holds the sequencer only
// when it has another beat to load. Reset empties the list through per-slot
// valid bits (no clearing pass) and sets active_entries to 8.
module lru_recency_list
(
    input  logic                  clk,
    input  logic                  rst_n,
    lrul_access_if.sink           access,
    lrul_result_if.source         result,
    lrul_cfg_if.sink              cfg
);
    import lrul_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_REPORT = 3'd2;
    localparam logic [2:0] S_DUMP   = 3'd3;

    logic [2:0]       state_reg, state_next;
    idx_t             idx_reg, idx_next;
    idx_t             last_idx_reg, last_idx_next;
    logic             final_reg, final_next;
    tag_t             tag_reg, tag_next;
    tag_t             carry_reg, carry_next;
    logic             hit_reg, hit_next;
    idx_t             pos_reg, pos_next;
    logic             ev_valid_reg, ev_valid_next;
    tag_t             ev_tag_reg, ev_tag_next;
    logic             out_valid_reg, out_valid_next;
    lrul_res_t        out_reg, out_next;
    logic [CFG_W-1:0] active_reg;

    lrul_wr_t         wr;
    idx_t             rd_addr;
    tag_t             rd_data;
    idx_t             cfg_last;
    logic             accept;
    logic             out_free;
    logic             match;
    logic             empty;
    logic             at_end;

    lrul_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (active_reg == '0)
        begin
            cfg_last = '0;
        end
        else if (active_reg > CFG_W'(DEPTH))
        begin
            cfg_last = IDX_W'(DEPTH - 1);
        end
        else
        begin
            cfg_last = IDX_W'(active_reg - CFG_W'(1));
        end
    end

    assign access.ready = (state_reg == S_IDLE);
    assign accept       = access.valid && access.ready;
    assign cfg.ready    = 1'b1;
    assign out_free     = !out_valid_reg || result.ready;

    assign match  = (rd_data == tag_reg);
    assign empty  = (rd_data == '0);
    assign at_end = (idx_reg == last_idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        final_next     = final_reg;
        tag_next       = tag_reg;
        carry_next     = carry_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        ev_valid_next  = ev_valid_reg;
        ev_tag_next    = ev_tag_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        wr             = '{en: 1'b0, addr: idx_reg, data: carry_reg};
        rd_addr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tag_next      = access.tag_value;
                    carry_next    = access.tag_value;
                    final_next    = access.final_access;
                    last_idx_next = cfg_last;
                    idx_next      = '0;
                    hit_next      = 1'b0;
                    pos_next      = '0;
                    ev_valid_next = 1'b0;
                    ev_tag_next   = '0;
                    state_next    = (access.tag_value == '0) ? S_REPORT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rotate: slot idx takes the value carried from the slot ahead
                wr.en = 1'b1;
                if (match || empty || at_end)
                begin
                    hit_next      = match;
                    pos_next      = idx_reg;
                    ev_valid_next = !match && !empty;
                    ev_tag_next   = (!match && !empty) ? rd_data : '0;
                    state_next    = S_REPORT;
                end
                else
                begin
                    carry_next = rd_data;
                    idx_next   = idx_reg + IDX_W'(1);
                    rd_addr    = idx_reg + IDX_W'(1);
                end
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.is_entry_dump = 1'b0;
                    out_next.hit           = hit_reg;
                    out_next.found_position = POS_W'(pos_reg);
                    out_next.evicted_valid = ev_valid_reg;
                    out_next.evicted_tag   = ev_tag_reg;
                    out_next.dump_tag      = '0;
                    out_next.last          = !final_reg;
                    idx_next               = '0;
                    state_next             = final_reg ? S_DUMP : S_IDLE;
                end
            end
            S_DUMP:
            begin
                rd_addr = idx_reg;
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.is_entry_dump  = 1'b1;
                    out_next.hit            = 1'b0;
                    out_next.found_position = '0;
                    out_next.evicted_valid  = 1'b0;
                    out_next.evicted_tag    = '0;
                    out_next.dump_tag       = rd_data;
                    out_next.last           = at_end;
                    if (at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= CFG_W'(DEPTH);
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                active_reg <= cfg.active_entries;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        carry_reg    <= carry_next;
        hit_reg      <= hit_next;
        pos_reg      <= pos_next;
        ev_valid_reg <= ev_valid_next;
        ev_tag_reg   <= ev_tag_next;
        out_reg      <= out_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.is_entry_dump  = out_reg.is_entry_dump;
    assign result.hit            = out_reg.hit;
    assign result.found_position = out_reg.found_position;
    assign result.evicted_valid  = out_reg.evicted_valid;
    assign result.evicted_tag    = out_reg.evicted_tag;
    assign result.dump_tag       = out_reg.dump_tag;
    assign result.last           = out_reg.last;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_DUMP) |-> idx_reg <= last_idx_reg)
        else $error("slot index beyond active list");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN || state_reg == S_REPORT))
        else $error("accepted access did not start a scan or report");

    a_write_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> state_reg == S_SCAN)
        else $error("list write outside scan");

    a_dump_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.is_entry_dump) |->
            (!out_reg.hit && !out_reg.evicted_valid && out_reg.evicted_tag == '0))
        else $error("dump beat carries access report fields");

    a_evict_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && !match && !empty) |-> (at_end || state_next == S_SCAN))
        else $error("scan stopped early without hit or empty slot");

endmodule
